// ===== design/hsd_pkg.sv =====
package hsd_pkg;

    localparam int NODE_W       = 7;
    localparam int TREE_NODES   = 1 << NODE_W;
    localparam int SYM_W        = 7;
    localparam int LEN_W        = 6;
    localparam int CODE_COUNT   = 37;
    localparam int CODE_MAX_LEN = 9;
    localparam int CODE_LEN_W   = 4;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [SYM_W-1:0] END_SYMBOL  = 7'h20;
    localparam logic [LEN_W-1:0] LEN_RESET   = 6'd32;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG = 2'd2;

    // What the tree walker found for one bit that produced a result.
    typedef enum logic [1:0] {
        EV_SYMBOL,
        EV_END,
        EV_UNKNOWN
    } event_kind_t;

    typedef struct packed {
        event_kind_t      kind;
        logic [SYM_W-1:0] sym;
    } event_t;

    // Code bits are written as they appear in the code, first bit in bit len-1.
    typedef struct packed {
        logic [CODE_LEN_W-1:0]   len;
        logic [CODE_MAX_LEN-1:0] bits;
        logic [SYM_W-1:0]        sym;
    } code_t;

    typedef struct packed {
        logic [1:0][NODE_W-1:0] child;
        logic [SYM_W-1:0]       leaf;
    } node_t;

    typedef node_t [TREE_NODES-1:0] rom_t;

    localparam code_t CODE_TABLE [CODE_COUNT] = '{
        '{4'd5, 9'b11110,    7'h61}, '{4'd4, 9'b0101,     7'h62},
        '{4'd5, 9'b01000,    7'h63}, '{4'd6, 9'b110001,   7'h64},
        '{4'd6, 9'b110000,   7'h65}, '{4'd6, 9'b010011,   7'h66},
        '{4'd5, 9'b11010,    7'h67}, '{4'd5, 9'b00011,    7'h68},
        '{4'd7, 9'b1111110,  7'h69}, '{4'd9, 9'b000101110, 7'h6a},
        '{4'd6, 9'b010010,   7'h6b}, '{4'd5, 9'b11101,    7'h6c},
        '{4'd5, 9'b01101,    7'h6d}, '{4'd6, 9'b001101,   7'h6e},
        '{4'd7, 9'b1111111,  7'h6f}, '{4'd8, 9'b11011001, 7'h71},
        '{4'd5, 9'b11001,    7'h70}, '{4'd5, 9'b11100,    7'h72},
        '{4'd4, 9'b0010,     7'h73}, '{4'd5, 9'b01100,    7'h74},
        '{4'd5, 9'b00001,    7'h75}, '{4'd7, 9'b1101110,  7'h76},
        '{4'd5, 9'b00000,    7'h77}, '{4'd5, 9'b00111,    7'h78},
        '{4'd7, 9'b0001010,  7'h79}, '{4'd8, 9'b11011000, 7'h7a},
        '{4'd2, 9'b10,       7'h20},
        '{4'd8, 9'b11111011, 7'h30}, '{4'd7, 9'b1111100,  7'h31},
        '{4'd6, 9'b001100,   7'h32}, '{4'd7, 9'b1101101,  7'h33},
        '{4'd8, 9'b11111010, 7'h34}, '{4'd8, 9'b00010110, 7'h35},
        '{4'd7, 9'b1101111,  7'h36}, '{4'd5, 9'b01111,    7'h37},
        '{4'd6, 9'b000100,   7'h38}, '{4'd5, 9'b01110,    7'h39}
    };

    // Builds the prefix tree at elaboration. Nodes are numbered in the order
    // they are first reached; child 0 means no branch since the root is
    // never a child.
    function automatic rom_t build_rom();
        rom_t rom;
        int   used;
        int   cur;
        int   b;
        int   len;
        rom  = '0;
        used = 1;
        for (int e = 0; e < CODE_COUNT; e++)
        begin
            cur = 0;
            len = int'(CODE_TABLE[e].len);
            for (int i = 0; i < len; i++)
            begin
                b = int'(CODE_TABLE[e].bits[len - 1 - i]);
                if (rom[cur].child[b] == '0 && used < TREE_NODES)
                begin
                    rom[cur].child[b] = NODE_W'(used);
                    used++;
                end
                cur = int'(rom[cur].child[b]);
            end
            rom[cur].leaf = CODE_TABLE[e].sym;
        end
        return rom;
    endfunction

    localparam rom_t TREE_ROM = build_rom();

endpackage

// ===== design/hsd_front.sv =====
module hsd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            bit_valid,
    input  logic            code_bit,
    input  logic            queue_full,
    output logic            bit_ready,
    output logic            push,
    output hsd_pkg::event_t push_event
);
    import hsd_pkg::*;

    logic [NODE_W-1:0] node_reg;
    logic [NODE_W-1:0] node_next;
    logic [NODE_W-1:0] child;
    logic [SYM_W-1:0]  leaf;
    logic              take;

    assign bit_ready = !queue_full;
    assign take      = bit_valid && bit_ready;
    assign child     = TREE_ROM[node_reg].child[code_bit];
    assign leaf      = TREE_ROM[child].leaf;

    always_comb
    begin
        node_next       = node_reg;
        push            = 1'b0;
        push_event.kind = EV_SYMBOL;
        push_event.sym  = leaf;
        if (take)
        begin
            priority if (child == '0)
            begin
                push            = 1'b1;
                push_event.kind = EV_UNKNOWN;
                node_next       = '0;
            end
            else if (leaf == '0)
            begin
                node_next = child;
            end
            else if (leaf == END_SYMBOL)
            begin
                push            = 1'b1;
                push_event.kind = EV_END;
                node_next       = '0;
            end
            else
            begin
                push      = 1'b1;
                node_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_reg <= '0;
        end
        else
        begin
            node_reg <= node_next;
        end
    end

endmodule

// ===== design/hsd_queue.sv =====
module hsd_queue #(
    parameter int DEPTH = hsd_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hsd_pkg::event_t push_event,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output hsd_pkg::event_t head
);
    import hsd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    event_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_event;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/hsd_back.sv =====
module hsd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [hsd_pkg::LEN_W-1:0] cfg_wdata,
    input  logic                      ev_valid,
    input  hsd_pkg::event_t           ev,
    output logic                      ev_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [hsd_pkg::SYM_W-1:0] out_symbol,
    output logic                      out_end,
    output logic [1:0]                out_error
);
    import hsd_pkg::*;

    logic [LEN_W-1:0] max_len_reg;
    logic [LEN_W-1:0] cnt_reg;
    logic [LEN_W-1:0] cnt_next;
    logic             valid_reg;
    logic [SYM_W-1:0] symbol_reg;
    logic [SYM_W-1:0] symbol_next;
    logic             end_reg;
    logic             end_next;
    logic [1:0]       error_reg;
    logic [1:0]       error_next;
    logic             too_long;

    assign ev_pop     = ev_valid && (!valid_reg || out_ready);
    assign out_valid  = valid_reg;
    assign out_symbol = symbol_reg;
    assign out_end    = end_reg;
    assign out_error  = error_reg;

    // The symbol that would pass the limit is dropped and reported instead.
    assign too_long = ({1'b0, cnt_reg} + 1'b1) > {1'b0, max_len_reg};

    always_comb
    begin
        cnt_next    = '0;
        symbol_next = '0;
        end_next    = 1'b0;
        error_next  = ERR_NONE;
        unique case (ev.kind)
            EV_SYMBOL:
            begin
                if (too_long)
                begin
                    error_next = ERR_TOO_LONG;
                end
                else
                begin
                    symbol_next = ev.sym;
                    cnt_next    = cnt_reg + 1'b1;
                end
            end
            EV_END:
            begin
                end_next = 1'b1;
            end
            EV_UNKNOWN:
            begin
                error_next = ERR_UNKNOWN;
            end
            default:
            begin
                error_next = ERR_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ev_pop)
        begin
            symbol_reg <= symbol_next;
            end_reg    <= end_next;
            error_reg  <= error_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= LEN_RESET;
            cnt_reg     <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
            if (ev_pop)
            begin
                cnt_reg   <= cnt_next;
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== design/huffman_symbol_string_decoder.sv =====
// Channel    Direction  Ports            Contents
// s_axis     in         tvalid/tready    tdata[0] code_bit
// m_axis     out        tvalid/tready    tdata[6:0] symbol, tlast end_of_string,
//                                        tuser[1:0] error_code
// cfg        in         cfg_we           cfg_wdata[5:0] max_string_length
//
// One code bit is taken every cycle; the tree walk is a single ROM lookup.
// A result passes through the event queue and then the output register before it
// reaches m_axis. s_axis stalls only when the event queue is full, which
// happens when m_axis holds back results. Reset returns the walk to the root,
// clears the symbol count and sets the length limit to 32.
module huffman_symbol_string_decoder #(
    parameter int QUEUE_DEPTH = hsd_pkg::QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,  // [0] code_bit
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,  // [6:0] symbol
    output logic                      m_axis_tlast,  // end_of_string
    output logic [1:0]                m_axis_tuser,  // [1:0] error_code
    input  logic                      cfg_we,
    input  logic [hsd_pkg::LEN_W-1:0] cfg_wdata
);
    import hsd_pkg::*;

    logic             push;
    event_t           push_event;
    logic             queue_full;
    logic             queue_not_empty;
    event_t           head;
    logic             pop;
    logic [SYM_W-1:0] out_symbol;

    hsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bit_valid  (s_axis_tvalid),
        .code_bit   (s_axis_tdata[0]),
        .queue_full (queue_full),
        .bit_ready  (s_axis_tready),
        .push       (push),
        .push_event (push_event)
    );

    hsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_event (push_event),
        .pop        (pop),
        .full       (queue_full),
        .not_empty  (queue_not_empty),
        .head       (head)
    );

    hsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .ev_valid   (queue_not_empty),
        .ev         (head),
        .ev_pop     (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_symbol (out_symbol),
        .out_end    (m_axis_tlast),
        .out_error  (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, out_symbol};

endmodule
